@@ sv/mtp_pkg.sv @@
// Shared types and constants for the multiplicity trigger prescaler.
// Used by mtp_event_acc, multiplicity_trigger_prescaler_unit and mtp_checker.
package mtp_pkg;

  localparam int MOD_W   = 5;
  localparam int CH_W    = 6;
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 7;
  localparam int TOT_W   = 11;
  localparam int MASK_W  = 25;
  localparam int PS_W    = 16;
  localparam int LIM_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 120;

  // output tdata bit offsets
  localparam int OFS_HIT    = 0;
  localparam int OFS_TOTAL  = 1;
  localparam int OFS_ONE    = 12;
  localparam int OFS_TWO    = 37;
  localparam int OFS_MANY   = 62;
  localparam int OFS_ACC    = 87;
  localparam int OFS_REC    = 112;
  localparam int OFS_SINGLE = 113;
  localparam int OFS_COSMIC = 114;
  localparam int OFS_PASS   = 115;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_PS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COSMIC_PS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

  localparam logic [PS_W-1:0]  SINGLE_PS_RST = 16'd1;
  localparam logic [PS_W-1:0]  COSMIC_PS_RST = 16'd1;
  localparam logic [LIM_W-1:0] LIMIT_RST     = 7'd10;

  localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;
  localparam logic [TOT_W-1:0] TOT_MAX   = 11'd2047;
  localparam logic [CNT_W-1:0] CNT_TWO   = 7'd2;
  localparam logic [TOT_W-1:0] TOT_ONE   = 11'd1;
  localparam logic [TOT_W-1:0] TOT_TWO   = 11'd2;

  typedef struct packed {
    logic             step;
    logic             hit;
    logic [MOD_W-1:0] module_idx;
    logic             last;
  } acc_req_t;

  typedef struct packed {
    logic [TOT_W-1:0]  total_hits;
    logic [MASK_W-1:0] fired_one_mask;
    logic [MASK_W-1:0] fired_two_mask;
    logic [MASK_W-1:0] too_many_mask;
    logic [MASK_W-1:0] accepted_mask;
    logic              recorded;
    logic              single_evt;
    logic              cosmic_evt;
    logic              prescale_pass;
  } summary_t;

endpackage

@@ sv/mtp_event_acc.sv @@
// Per-module and per-event hit counting, event classification and prescaling.
// Holds the configuration registers. Depends on mtp_pkg.
module mtp_event_acc #(
  parameter int MODULES = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mtp_pkg::acc_req_t                  req_i,
  input  logic                               cfg_we_i,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output mtp_pkg::summary_t                  sum_o
);

  logic [mtp_pkg::CNT_W-1:0] cnt_q   [MODULES];
  logic [mtp_pkg::CNT_W-1:0] cnt_d   [MODULES];
  logic [mtp_pkg::TOT_W-1:0] tot_q, tot_d;
  logic [mtp_pkg::PS_W-1:0]  sps_q, cps_q;
  logic [mtp_pkg::LIM_W-1:0] lim_q;
  logic [mtp_pkg::PS_W-1:0]  sres_q, sres_d, cres_q, cres_d;

  logic [mtp_pkg::PS_W:0]    s_next, c_next;
  logic                      s_wrap, c_wrap;
  logic [mtp_pkg::TOT_W-1:0] lim_ext;
  logic                      fire, single, cosmic, pass;
  logic [mtp_pkg::MASK_W-1:0] one_m, two_m, many_m;

  assign fire    = req_i.step && req_i.last;
  assign lim_ext = mtp_pkg::TOT_W'(lim_q);

  always_comb begin
    one_m  = '0;
    two_m  = '0;
    many_m = '0;
    for (int k = 0; k < MODULES; k++) begin
      if (req_i.step && req_i.hit && (req_i.module_idx == mtp_pkg::MOD_W'(k)) &&
          (cnt_q[k] != mtp_pkg::CNT_MAX)) begin
        cnt_d[k] = cnt_q[k] + 1'b1;
      end else begin
        cnt_d[k] = cnt_q[k];
      end
      one_m[k]  = (cnt_d[k] != '0);
      two_m[k]  = (cnt_d[k] >= mtp_pkg::CNT_TWO);
      many_m[k] = (cnt_d[k] >= lim_q);
    end
  end

  assign tot_d = (req_i.step && req_i.hit && (tot_q != mtp_pkg::TOT_MAX)) ?
                 tot_q + 1'b1 : tot_q;

  assign single = (tot_d == mtp_pkg::TOT_ONE);
  assign cosmic = (tot_d >= lim_ext);

  assign s_next = {1'b0, sres_q} + 1'b1;
  assign c_next = {1'b0, cres_q} + 1'b1;
  assign s_wrap = (s_next >= {1'b0, sps_q});
  assign c_wrap = (c_next >= {1'b0, cps_q});
  assign sres_d = s_wrap ? '0 : s_next[mtp_pkg::PS_W-1:0];
  assign cres_d = c_wrap ? '0 : c_next[mtp_pkg::PS_W-1:0];

  always_comb begin
    if (cosmic && (cps_q != '0)) begin
      pass = c_wrap;
    end else if (single && (sps_q != '0)) begin
      pass = s_wrap;
    end else if ((single && (sps_q == '0)) || (cosmic && (cps_q == '0))) begin
      pass = 1'b0;
    end else begin
      pass = 1'b1;
    end
  end

  always_comb begin
    sum_o.total_hits     = tot_d;
    sum_o.fired_one_mask = one_m;
    sum_o.fired_two_mask = two_m;
    sum_o.too_many_mask  = many_m;
    sum_o.recorded       = (tot_d >= mtp_pkg::TOT_TWO) && (tot_d <= lim_ext);
    sum_o.accepted_mask  = sum_o.recorded ? one_m : '0;
    sum_o.single_evt     = single;
    sum_o.cosmic_evt     = cosmic;
    sum_o.prescale_pass  = pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MODULES; k++) begin
        cnt_q[k] <= '0;
      end
      tot_q  <= '0;
      sres_q <= '0;
      cres_q <= '0;
      sps_q  <= mtp_pkg::SINGLE_PS_RST;
      cps_q  <= mtp_pkg::COSMIC_PS_RST;
      lim_q  <= mtp_pkg::LIMIT_RST;
    end else begin
      if (req_i.step) begin
        for (int k = 0; k < MODULES; k++) begin
          cnt_q[k] <= fire ? '0 : cnt_d[k];
        end
        tot_q <= fire ? '0 : tot_d;
      end
      if (cfg_we_i && (cfg_idx_i == mtp_pkg::CFG_SINGLE_PS)) begin
        sres_q <= '0;
      end else if (fire && single && (sps_q != '0)) begin
        sres_q <= sres_d;
      end
      if (cfg_we_i && (cfg_idx_i == mtp_pkg::CFG_COSMIC_PS)) begin
        cres_q <= '0;
      end else if (fire && cosmic && (cps_q != '0)) begin
        cres_q <= cres_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mtp_pkg::CFG_SINGLE_PS: sps_q <= cfg_wdata_i;
          mtp_pkg::CFG_COSMIC_PS: cps_q <= cfg_wdata_i;
          mtp_pkg::CFG_LIMIT:     lim_q <= cfg_wdata_i[mtp_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sv/multiplicity_trigger_prescaler_unit.sv @@
// Top level of the multiplicity trigger prescaler: threshold RAM, sample
// pipeline and output register. Depends on mtp_pkg and mtp_event_acc.
//
// Input stream (s_axis): tuser selects a threshold load (0) or a channel
// sample (1); tdata carries module, channel and the signed value; tlast
// closes an event on a sample. Every request yields exactly one result on
// m_axis; tuser high there marks an event summary.
// On accept, the threshold RAM is written (load) or read (sample) at
// module * CHANNELS + channel.
// In the compare stage the registered RAM word is compared with the sample,
// the module and event counters are updated and, on tlast, the summary and
// prescale decision are formed and loaded into the output register.
// Throughput is one request per cycle while the output register is not
// stalled, set by the single RAM port used once per request.
// Reset clears counters, residues, valid flags and restores the register
// defaults; the threshold RAM is not cleared and must be loaded first.
// When m_axis_tready is low the output register holds; one more request
// can still enter and wait in the compare stage, then s_axis_tready drops.
// Configuration writes are taken in any cycle and are meant for idle time.
module multiplicity_trigger_prescaler_unit #(
  parameter int MODULES  = 25,
  parameter int CHANNELS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // module_req[4:0], channel[10:5], value[26:11], zero fill
  input  logic [mtp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit, total_hits, fired_one_mask, fired_two_mask, too_many_mask,
  // accepted_mask, recorded, single_evt, cosmic_evt, prescale_pass, zero fill
  output logic [mtp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // event_done
  output logic                                m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int DEPTH  = MODULES * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [mtp_pkg::MOD_W:0] MOD_LIM = (mtp_pkg::MOD_W + 1)'(MODULES);
  localparam logic [mtp_pkg::CH_W:0]  CH_LIM  = (mtp_pkg::CH_W + 1)'(CHANNELS);

  logic [mtp_pkg::VAL_W-1:0] thr_mem [DEPTH];
  logic [mtp_pkg::VAL_W-1:0] thr_rd_q;

  logic [mtp_pkg::MOD_W-1:0] in_mod;
  logic [mtp_pkg::CH_W-1:0]  in_ch;
  logic [mtp_pkg::VAL_W-1:0] in_val;
  logic                      in_range;
  logic [ADDR_W-1:0]         in_addr;
  logic                      in_acc, out_free, s1_adv;

  logic                      s1_vld_q;
  logic                      s1_type_q, s1_range_q, s1_last_q;
  logic [mtp_pkg::MOD_W-1:0] s1_mod_q;
  logic [mtp_pkg::VAL_W-1:0] s1_val_q;

  logic                      hit, evt;
  mtp_pkg::acc_req_t         acc_req;
  mtp_pkg::summary_t         sum;

  logic                               out_vld_q;
  logic [mtp_pkg::OUT_TDATA_W-1:0]    out_data_q, out_data_d;
  logic                               out_user_q;

  assign in_mod   = s_axis_tdata[mtp_pkg::MOD_W-1:0];
  assign in_ch    = s_axis_tdata[mtp_pkg::MOD_W +: mtp_pkg::CH_W];
  assign in_val   = s_axis_tdata[mtp_pkg::MOD_W + mtp_pkg::CH_W +: mtp_pkg::VAL_W];
  assign in_range = ({1'b0, in_mod} < MOD_LIM) && ({1'b0, in_ch} < CH_LIM);
  assign in_addr  = ADDR_W'(in_mod * CHANNELS + in_ch);

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_vld_q && out_free;

  // threshold RAM: one access per in-range request, none when out of range
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      if (s_axis_tuser == mtp_pkg::REQ_LOAD) begin
        thr_mem[in_addr] <= in_val;
      end else begin
        thr_rd_q <= thr_mem[in_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_type_q  <= s_axis_tuser;
      s1_range_q <= in_range;
      s1_last_q  <= s_axis_tlast;
      s1_mod_q   <= in_mod;
      s1_val_q   <= in_val;
    end
  end

  assign hit = (s1_type_q == mtp_pkg::REQ_SAMPLE) && s1_range_q &&
               ($signed(s1_val_q) > $signed(thr_rd_q));
  assign evt = (s1_type_q == mtp_pkg::REQ_SAMPLE) && s1_last_q;

  always_comb begin
    acc_req.step       = s1_adv && (s1_type_q == mtp_pkg::REQ_SAMPLE);
    acc_req.hit        = hit;
    acc_req.module_idx = s1_mod_q;
    acc_req.last       = s1_last_q;
  end

  mtp_event_acc #(
    .MODULES (MODULES)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (acc_req),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sum_o       (sum)
  );

  always_comb begin
    out_data_d = '0;
    out_data_d[mtp_pkg::OFS_HIT] = hit;
    if (evt) begin
      out_data_d[mtp_pkg::OFS_TOTAL +: mtp_pkg::TOT_W] = sum.total_hits;
      out_data_d[mtp_pkg::OFS_ONE   +: mtp_pkg::MASK_W] = sum.fired_one_mask;
      out_data_d[mtp_pkg::OFS_TWO   +: mtp_pkg::MASK_W] = sum.fired_two_mask;
      out_data_d[mtp_pkg::OFS_MANY  +: mtp_pkg::MASK_W] = sum.too_many_mask;
      out_data_d[mtp_pkg::OFS_ACC   +: mtp_pkg::MASK_W] = sum.accepted_mask;
      out_data_d[mtp_pkg::OFS_REC]    = sum.recorded;
      out_data_d[mtp_pkg::OFS_SINGLE] = sum.single_evt;
      out_data_d[mtp_pkg::OFS_COSMIC] = sum.cosmic_evt;
      out_data_d[mtp_pkg::OFS_PASS]   = sum.prescale_pass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
      out_user_q <= evt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ sv/mtp_checker.sv @@
// Port-level checks for multiplicity_trigger_prescaler_unit, bound to it.
// Depends on mtp_pkg for the output field offsets.
module mtp_port_checks (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mtp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  logic [mtp_pkg::MASK_W-1:0] one_m, two_m, acc_m;

  assign one_m = m_axis_tdata[mtp_pkg::OFS_ONE +: mtp_pkg::MASK_W];
  assign two_m = m_axis_tdata[mtp_pkg::OFS_TWO +: mtp_pkg::MASK_W];
  assign acc_m = m_axis_tdata[mtp_pkg::OFS_ACC +: mtp_pkg::MASK_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_no_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[mtp_pkg::OUT_TDATA_W-1:mtp_pkg::OFS_TOTAL] == '0))
    else $error("summary fields set on a non-final result");

  a_mask_nesting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      ((two_m & ~one_m) == '0) && ((acc_m == '0) || (acc_m == one_m)))
    else $error("event masks inconsistent");

endmodule

bind multiplicity_trigger_prescaler_unit mtp_port_checks u_mtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/mtp_checker.sv @@
`timescale 1ns / 100ps
// Checker for the multiplicity trigger prescaler: mirrors the threshold RAM, hit counts,
// prescale residues and registers, predicts each result word and compares it.
// Depends on mtp_pkg; instantiated beside the unit by tb.
module mtp_checker
  import mtp_pkg::*;
#(
  parameter int MODULES  = 25,
  parameter int CHANNELS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     requests_o,
  output int                     events_o,
  output int                     singles_o,
  output int                     cosmics_o,
  output int                     recorded_o
);

  typedef struct packed {
    logic     hit;
    logic     done;
    summary_t evt;
  } trig_word_t;

  logic signed [VAL_W-1:0] thr_mem [MODULES*CHANNELS];
  logic [CNT_W-1:0]        mod_cnt [MODULES];
  logic [TOT_W-1:0]        ev_total;
  logic [PS_W-1:0]         single_res, cosmic_res, single_ps, cosmic_ps;
  logic [LIM_W-1:0]        limit;
  trig_word_t              trig_word_q [$];
  trig_word_t              want_w, got_w;

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      // keep the log short when the unit is badly off
      if (fail_count_o < 60)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic trigger_predict(input logic rtype, input logic [IN_TDATA_W-1:0] data,
                                 input logic lst);
    logic [MOD_W-1:0]        m;
    logic [CH_W-1:0]         c;
    logic signed [VAL_W-1:0] v;
    logic                    in_range;
    logic [PS_W:0]           nxt;
    int                      idx;
    trig_word_t              w;
    m = data[MOD_W-1:0];
    c = data[MOD_W +: CH_W];
    v = data[MOD_W+CH_W +: VAL_W];
    in_range = (m < MODULES) && (c < CHANNELS);
    idx = m * CHANNELS + c;
    w = '0;
    if (rtype == REQ_LOAD) begin
      if (in_range) thr_mem[idx] = v;
    end else begin
      if (in_range && v > thr_mem[idx]) begin
        w.hit = 1'b1;
        if (mod_cnt[m] != CNT_MAX) mod_cnt[m]++;
        if (ev_total != TOT_MAX) ev_total++;
      end
      if (lst) begin
        w.done = 1'b1;
        w.evt.total_hits = ev_total;
        for (int k = 0; k < MODULES; k++) begin
          w.evt.fired_one_mask[k] = (mod_cnt[k] != '0);
          w.evt.fired_two_mask[k] = (mod_cnt[k] >= CNT_TWO);
          w.evt.too_many_mask[k]  = (mod_cnt[k] >= limit);
        end
        w.evt.recorded   = (ev_total >= TOT_TWO) && (ev_total <= limit);
        w.evt.single_evt = (ev_total == TOT_ONE);
        w.evt.cosmic_evt = (ev_total >= limit);
        w.evt.accepted_mask = w.evt.recorded ? w.evt.fired_one_mask : '0;
        w.evt.prescale_pass = 1'b1;
        if (w.evt.single_evt && single_ps == '0) w.evt.prescale_pass = 1'b0;
        if (w.evt.cosmic_evt && cosmic_ps == '0) w.evt.prescale_pass = 1'b0;
        // cosmic rule goes second so it wins when both apply
        if (w.evt.single_evt && single_ps != '0) begin
          nxt = single_res + 1'b1;
          w.evt.prescale_pass = (nxt >= single_ps);
          single_res = w.evt.prescale_pass ? '0 : nxt[PS_W-1:0];
        end
        if (w.evt.cosmic_evt && cosmic_ps != '0) begin
          nxt = cosmic_res + 1'b1;
          w.evt.prescale_pass = (nxt >= cosmic_ps);
          cosmic_res = w.evt.prescale_pass ? '0 : nxt[PS_W-1:0];
        end
        for (int k = 0; k < MODULES; k++) mod_cnt[k] = '0;
        ev_total = '0;
        events_o++;
        if (w.evt.single_evt) singles_o++;
        if (w.evt.cosmic_evt) cosmics_o++;
        if (w.evt.recorded) recorded_o++;
      end
    end
    trig_word_q.push_back(w);
    pending_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MODULES; k++) mod_cnt[k] = '0;
      ev_total     = '0;
      single_res   = '0;
      cosmic_res   = '0;
      single_ps    = SINGLE_PS_RST;
      cosmic_ps    = COSMIC_PS_RST;
      limit        = LIMIT_RST;
      trig_word_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      requests_o   = 0;
      events_o     = 0;
      singles_o    = 0;
      cosmics_o    = 0;
      recorded_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (trig_word_q.size() == 0) begin
          $display("%0t: result with nothing expected, tdata %0h tuser %0b",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          want_w = trig_word_q.pop_front();
          pending_o--;
          got_w.hit                = m_axis_tdata[OFS_HIT];
          got_w.done               = m_axis_tuser;
          got_w.evt.total_hits     = m_axis_tdata[OFS_TOTAL +: TOT_W];
          got_w.evt.fired_one_mask = m_axis_tdata[OFS_ONE +: MASK_W];
          got_w.evt.fired_two_mask = m_axis_tdata[OFS_TWO +: MASK_W];
          got_w.evt.too_many_mask  = m_axis_tdata[OFS_MANY +: MASK_W];
          got_w.evt.accepted_mask  = m_axis_tdata[OFS_ACC +: MASK_W];
          got_w.evt.recorded       = m_axis_tdata[OFS_REC];
          got_w.evt.single_evt     = m_axis_tdata[OFS_SINGLE];
          got_w.evt.cosmic_evt     = m_axis_tdata[OFS_COSMIC];
          got_w.evt.prescale_pass  = m_axis_tdata[OFS_PASS];
          field_check("hit", want_w.hit, got_w.hit);
          field_check("event_done", want_w.done, got_w.done);
          field_check("total_hits", want_w.evt.total_hits, got_w.evt.total_hits);
          field_check("fired_one_mask", want_w.evt.fired_one_mask,
                      got_w.evt.fired_one_mask);
          field_check("fired_two_mask", want_w.evt.fired_two_mask,
                      got_w.evt.fired_two_mask);
          field_check("too_many_mask", want_w.evt.too_many_mask, got_w.evt.too_many_mask);
          field_check("accepted_mask", want_w.evt.accepted_mask, got_w.evt.accepted_mask);
          field_check("recorded", want_w.evt.recorded, got_w.evt.recorded);
          field_check("single_evt", want_w.evt.single_evt, got_w.evt.single_evt);
          field_check("cosmic_evt", want_w.evt.cosmic_evt, got_w.evt.cosmic_evt);
          field_check("prescale_pass", want_w.evt.prescale_pass, got_w.evt.prescale_pass);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SINGLE_PS: begin
            single_ps  = cfg_wdata_i[PS_W-1:0];
            single_res = '0;
          end
          CFG_COSMIC_PS: begin
            cosmic_ps  = cfg_wdata_i[PS_W-1:0];
            cosmic_res = '0;
          end
          CFG_LIMIT: begin
            limit = cfg_wdata_i[LIM_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        trigger_predict(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        requests_o++;
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the trigger prescaler bench: clock, reset, request stimulus, output stalls,
// register settings and the verdict. Depends on mtp_pkg, mtp_checker and the unit.
module tb;
  import mtp_pkg::*;

  localparam int MODULES    = 25;
  localparam int CHANNELS   = 64;
  localparam int ITEMS      = 1450;
  localparam int PHASE_LEN  = 120;
  localparam int QUIET_MAX  = 4000;
  localparam int BIG_EVENT  = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  int fail_count, pending, requests, events, singles, cosmics, recorded;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int traffic_items = 0;
  int settings_used = 1;

  // stimulus-side view of which thresholds are loaded and with what
  int thr_mirror [MODULES*CHANNELS];
  bit thr_set    [MODULES*CHANNELS];
  int loaded_list [$];

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);

  multiplicity_trigger_prescaler_unit #(
    .MODULES  (MODULES),
    .CHANNELS (CHANNELS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mtp_checker #(
    .MODULES  (MODULES),
    .CHANNELS (CHANNELS)
  ) trig_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .requests_o    (requests),
    .events_o      (events),
    .singles_o     (singles),
    .cosmics_o     (cosmics),
    .recorded_o    (recorded)
  );

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic push_req(input logic rtype, input int mod, input int ch, input int val,
                          input logic lst);
    int i;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = rtype;
    s_axis_tlast  = lst;
    s_axis_tdata  = {5'd0, val[VAL_W-1:0], ch[CH_W-1:0], mod[MOD_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (rtype == REQ_LOAD && mod < MODULES && ch < CHANNELS) begin
      i = mod * CHANNELS + ch;
      if (!thr_set[i]) loaded_list.push_back(i);
      thr_set[i]    = 1'b1;
      thr_mirror[i] = val;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_settings(input int single_ps, input int cosmic_ps, input int lim);
    write_reg(CFG_SINGLE_PS, single_ps);
    write_reg(CFG_COSMIC_PS, cosmic_ps);
    write_reg(CFG_LIMIT, lim);
    settings_used++;
  endtask

  function automatic int pick_value(input int thr, input bit want_hit);
    int span;
    if (want_hit && thr < 32767) begin
      span = 32767 - thr;
      if ($urandom_range(0, 3) != 0 && span > 64) span = 64;
      return thr + $urandom_range(1, span);
    end
    span = thr + 32768;
    if ($urandom_range(0, 3) != 0 && span > 64) span = 64;
    return thr - $urandom_range(0, span);
  endfunction

  task automatic random_load();
    int mod, ch, val;
    mod = ($urandom_range(0, 99) < 12) ? $urandom_range(MODULES, 31)
                                       : $urandom_range(0, MODULES - 1);
    ch  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    val = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 400) - 200
                                     : $urandom_range(0, 65535) - 32768;
    push_req(REQ_LOAD, mod, ch, val, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_traffic(input int n);
    int cnt, r, len, p_hit, f0, f1, idx;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        random_load();
        cnt++;
      end else if (r < 14) begin
        // sample on a module that does not exist; its last flag still closes the event
        push_req(REQ_SAMPLE, $urandom_range(MODULES, 31), $urandom_range(0, 63),
                 $urandom_range(0, 65535) - 32768, 1'($urandom_range(0, 1)));
        cnt++;
      end else begin
        r = $urandom_range(0, 99);
        len = (r < 60) ? $urandom_range(1, 4) :
              (r < 88) ? $urandom_range(5, 16) : $urandom_range(17, 72);
        case ($urandom_range(0, 4))
          0: p_hit = 0;
          1: p_hit = 25;
          2: p_hit = 50;
          3: p_hit = 85;
          default: p_hit = 100;
        endcase
        f0 = loaded_list[$urandom_range(0, loaded_list.size() - 1)] / CHANNELS;
        f1 = loaded_list[$urandom_range(0, loaded_list.size() - 1)] / CHANNELS;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 4) begin
            random_load();
            cnt++;
          end
          for (int t = 0; t < 6; t++) begin
            idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            if (idx / CHANNELS == f0 || idx / CHANNELS == f1) break;
          end
          push_req(REQ_SAMPLE, idx / CHANNELS, idx % CHANNELS,
                   pick_value(thr_mirror[idx], $urandom_range(0, 99) < p_hit),
                   i == len - 1);
        end
        cnt += len;
      end
    end
    traffic_items += cnt;
  endtask

  // one event long enough to saturate a module count
  task automatic saturating_event();
    for (int m = 0; m < MODULES; m++) push_req(REQ_LOAD, m, 0, -32768, 1'b0);
    for (int i = 0; i < BIG_EVENT; i++)
      push_req(REQ_SAMPLE, (i % 2 == 0) ? 0 : (i / 2) % MODULES, 0,
               $urandom_range(0, 65534) - 32767, i == BIG_EVENT - 1);
    traffic_items += MODULES + BIG_EVENT;
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin
    int phase;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: value and index extremes, ignored loads, strict compare, event closes
    push_req(REQ_LOAD,   0,  0, -32768, 1'b1);
    push_req(REQ_LOAD,  24, 63,  32767, 1'b0);
    push_req(REQ_LOAD,   3,  5,      0, 1'b0);
    push_req(REQ_LOAD,  25,  7,    123, 1'b0);
    push_req(REQ_LOAD,  31, 63,     -1, 1'b1);
    push_req(REQ_SAMPLE, 0,  0, -32768, 1'b0);
    push_req(REQ_SAMPLE, 0,  0, -32767, 1'b0);
    push_req(REQ_SAMPLE, 24, 63, 32767, 1'b0);
    push_req(REQ_SAMPLE, 3,  5,      1, 1'b0);
    push_req(REQ_SAMPLE, 3,  5,      0, 1'b0);
    push_req(REQ_SAMPLE, 31, 63,    -1, 1'b0);
    push_req(REQ_SAMPLE, 3,  5,  21845, 1'b0);
    push_req(REQ_SAMPLE, 25,  0, -21846, 1'b1);
    push_req(REQ_SAMPLE, 0,  0,  32767, 1'b1);
    push_req(REQ_SAMPLE, 24, 63, -32768, 1'b1);
    push_req(REQ_SAMPLE, 3,  5,     -1, 1'b1);
    push_req(REQ_SAMPLE, 3,  5,      7, 1'b0);
    push_req(REQ_SAMPLE, 30,  2,      0, 1'b1);

    for (int i = 0; i < 40; i++) random_load();
    traffic_items += 40;

    phase = 0;
    while (traffic_items < ITEMS) begin
      case (phase)
        0: ;
        1: apply_settings(3, 2, 4);
        2: apply_settings(0, 0, 2);
        3: apply_settings(65535, 65535, 64);
        4: apply_settings(2, 3, 1);
        5: apply_settings(1, 0, 0);
        6: apply_settings(0, 4, 1);
        7: apply_settings(1, 1, 64);
        default: apply_settings($urandom_range(0, 4), $urandom_range(0, 4),
                                $urandom_range(2, 12));
      endcase
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      if (phase == 3) saturating_event();
      run_traffic(PHASE_LEN);
      phase++;
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("tb: %0d requests over %0d register settings, %0d event summaries", requests,
             settings_used, events);
    $display("tb: events split as %0d single, %0d cosmic, %0d recorded", singles, cosmics,
             recorded);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
